// ----- rtl/salc_pkg.sv -----
// Package for the set-associative LRU cache lookup core.
// Widths, default geometry, state machine codes and the result word type.
// No dependencies.
package salc_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned WAY_FIELD_W = 2;

  // Default geometry; all three must be powers of two.
  localparam int unsigned SALC_NUM_SETS   = 128;
  localparam int unsigned SALC_WAYS       = 4;
  localparam int unsigned SALC_LINE_BYTES = 64;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } salc_state_t;

  // Outcome of one lookup, as handed from the policy logic to the top.
  typedef struct packed {
    logic                   hit;
    logic [WAY_FIELD_W-1:0] way;
    logic                   writeback_valid;
    logic [ADDR_W-1:0]      writeback_address;
  } salc_result_t;

endpackage

// ----- rtl/salc_req_if.sv -----
// Request channel: one access word (address and read/write).
// Depends on salc_pkg.
interface salc_req_if
  import salc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              req_type;

  modport source (output valid, output address, output req_type, input ready);
  modport sink   (input valid, input address, input req_type, output ready);
endinterface

// ----- rtl/salc_rsp_if.sv -----
// Response channel: one lookup result word per access.
// Depends on salc_pkg.
interface salc_rsp_if
  import salc_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [WAY_FIELD_W-1:0] way;
  logic                   writeback_valid;
  logic [ADDR_W-1:0]      writeback_address;
  logic [CNT_W-1:0]       hit_count;
  logic [CNT_W-1:0]       miss_count;

  modport source (output valid, output hit, output way, output writeback_valid,
                  output writeback_address, output hit_count, output miss_count,
                  input ready);
  modport sink   (input valid, input hit, input way, input writeback_valid,
                  input writeback_address, input hit_count, input miss_count,
                  output ready);
endinterface

// ----- rtl/salc_store.sv -----
// Tag and metadata memories of the cache, one row per set, plus the
// post-reset clearing pass over the metadata. Depends on salc_pkg.
module salc_store
  import salc_pkg::*;
#(
  parameter int unsigned NUM_SETS = SALC_NUM_SETS,
  parameter int unsigned WAYS     = SALC_WAYS,
  parameter int unsigned TAG_W    = 19,
  parameter int unsigned SET_W    = 7,
  parameter int unsigned RANK_W   = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [SET_W-1:0]           rd_set,
  input  logic                       wr_en,
  input  logic [SET_W-1:0]           wr_set,
  input  logic [WAYS*TAG_W-1:0]      wr_tag_row,
  input  logic [WAYS*(2+RANK_W)-1:0] wr_meta_row,
  output logic [WAYS*TAG_W-1:0]      rd_tag_row,
  output logic [WAYS*(2+RANK_W)-1:0] rd_meta_row,
  output logic                       clr_busy
);

  localparam int unsigned META_W = WAYS * (2 + RANK_W);

  // tags: undefined until written, never cleared
  logic [WAYS*TAG_W-1:0] tag_mem  [NUM_SETS];
  // meta row: valid bits, dirty bits, then one rank per way
  logic [META_W-1:0]     meta_mem [NUM_SETS];

  logic [SET_W-1:0]  clr_idx;
  logic [META_W-1:0] reset_row;
  logic              meta_we;
  logic [SET_W-1:0]  meta_wa;
  logic [META_W-1:0] meta_wd;

  always_comb begin
    reset_row = '0;
    for (int i = 0; i < WAYS; i++) begin
      reset_row[2*WAYS + i*RANK_W +: RANK_W] = RANK_W'(i);
    end
  end

  assign meta_we = clr_busy || wr_en;
  assign meta_wa = clr_busy ? clr_idx : wr_set;
  assign meta_wd = clr_busy ? reset_row : wr_meta_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      if (clr_idx == SET_W'(NUM_SETS - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !clr_busy) begin
      tag_mem[wr_set] <= wr_tag_row;
    end
    if (rd_en) begin
      rd_tag_row <= tag_mem[rd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    if (rd_en) begin
      rd_meta_row <= meta_mem[rd_set];
    end
  end

endmodule

// ----- rtl/salc_policy.sv -----
// Hit detection, LRU victim choice and row update for one set.
// Purely combinational; depends on salc_pkg.
module salc_policy
  import salc_pkg::*;
#(
  parameter int unsigned WAYS     = SALC_WAYS,
  parameter int unsigned TAG_W    = 19,
  parameter int unsigned SET_W    = 7,
  parameter int unsigned RANK_W   = 2,
  parameter int unsigned OFF_W    = 6,
  parameter int unsigned IDX_BITS = 7
) (
  input  logic [WAYS*TAG_W-1:0]      tag_row,
  input  logic [WAYS*(2+RANK_W)-1:0] meta_row,
  input  logic [TAG_W-1:0]           tag,
  input  logic [SET_W-1:0]           set_idx,
  input  logic                       wr,
  output salc_result_t               res,
  output logic [WAYS*TAG_W-1:0]      tag_row_next,
  output logic [WAYS*(2+RANK_W)-1:0] meta_row_next
);

  logic [WAYS-1:0]   valid_v;
  logic [WAYS-1:0]   dirty_v;
  logic [RANK_W-1:0] rank     [WAYS];
  logic [WAYS-1:0]   match_v;
  logic              hit;
  logic [RANK_W-1:0] hit_way;
  logic [RANK_W-1:0] victim;
  logic [RANK_W-1:0] sel;
  logic [RANK_W-1:0] old_rank;
  logic [TAG_W-1:0]  victim_tag;
  logic              wb;

  always_comb begin
    valid_v = meta_row[WAYS-1:0];
    dirty_v = meta_row[2*WAYS-1:WAYS];
    for (int i = 0; i < WAYS; i++) begin
      rank[i]    = meta_row[2*WAYS + i*RANK_W +: RANK_W];
      match_v[i] = valid_v[i] && (tag_row[i*TAG_W +: TAG_W] == tag);
    end
    hit = |match_v;
    // lowest matching way; LRU way is the one ranked zero
    hit_way = '0;
    victim  = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match_v[i]) begin
        hit_way = RANK_W'(i);
      end
      if (rank[i] == '0) begin
        victim = RANK_W'(i);
      end
    end
    sel        = hit ? hit_way : victim;
    old_rank   = rank[sel];
    victim_tag = tag_row[victim*TAG_W +: TAG_W];
    wb         = !hit && valid_v[victim] && dirty_v[victim];
  end

  always_comb begin
    tag_row_next  = tag_row;
    meta_row_next = meta_row;
    tag_row_next[sel*TAG_W +: TAG_W] = tag;
    meta_row_next[sel]               = 1'b1;
    meta_row_next[WAYS + sel]        = hit ? (dirty_v[sel] | wr) : wr;
    for (int i = 0; i < WAYS; i++) begin
      if (i == int'(sel)) begin
        meta_row_next[2*WAYS + i*RANK_W +: RANK_W] = RANK_W'(WAYS - 1);
      end else if (rank[i] > old_rank) begin
        meta_row_next[2*WAYS + i*RANK_W +: RANK_W] = rank[i] - 1'b1;
      end
    end
  end

  always_comb begin
    res.hit             = hit;
    res.way             = WAY_FIELD_W'(sel);
    res.writeback_valid = wb;
    if (wb) begin
      res.writeback_address = (ADDR_W'(victim_tag) << (OFF_W + IDX_BITS))
                            | (ADDR_W'(set_idx) << OFF_W);
    end else begin
      res.writeback_address = '0;
    end
  end

endmodule

// ----- rtl/set_assoc_lru_cache_lookup_core.sv -----
// Top level of the set-associative, true-LRU cache lookup core.
// Depends on salc_pkg, salc_req_if, salc_rsp_if, salc_store, salc_policy.
//
//   Channel  Dir  Word carried
//   -------  ---  ---------------------------------------------------------
//   req      in   address[31:0], req_type (0 read, 1 write)
//   rsp      out  hit, way[1:0], writeback_valid, writeback_address[31:0],
//                 hit_count[31:0], miss_count[31:0]
//
// Flow: accept issues the read of the set's tag and metadata rows; in the
//   lookup state that follows, the core compares, updates and writes the rows
//   back. The read-modify-write on the one set row paces the core.
// Reset: after rst the metadata memory is cleared, one set per cycle, over
//   all NUM_SETS sets; req.ready stays low meanwhile.
// Stalls: a new access is taken while the last result still waits in the
//   output register; its lookup holds (rows kept in the read registers) until
//   rsp takes that result.
module set_assoc_lru_cache_lookup_core
  import salc_pkg::*;
#(
  parameter int unsigned NUM_SETS   = SALC_NUM_SETS,
  parameter int unsigned WAYS       = SALC_WAYS,
  parameter int unsigned LINE_BYTES = SALC_LINE_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  salc_req_if.sink   req,
  salc_rsp_if.source rsp
);

  // Address split: offset | set index | tag (all sizes powers of two)
  localparam int unsigned OFF_W    = $clog2(LINE_BYTES);
  localparam int unsigned IDX_BITS = $clog2(NUM_SETS);
  localparam int unsigned SET_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int unsigned TAG_W    = ADDR_W - OFF_W - IDX_BITS;
  localparam int unsigned RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned META_W   = WAYS * (2 + RANK_W);

  salc_state_t state, state_next;

  // access held for the lookup state
  logic [TAG_W-1:0] req_tag;
  logic [SET_W-1:0] req_set;
  logic             req_wr;

  logic [TAG_W-1:0] in_tag;
  logic [SET_W-1:0] in_set;

  logic              accept;
  logic              advance;
  logic              rd_en;
  logic              wr_en;
  logic              clr_busy;

  logic [WAYS*TAG_W-1:0] rd_tag_row, wr_tag_row;
  logic [META_W-1:0]     rd_meta_row, wr_meta_row;
  salc_result_t          res;

  // output register
  logic             out_valid;
  salc_result_t     out_res;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;

  assign in_tag = req.address[OFF_W + IDX_BITS +: TAG_W];
  generate
    if (IDX_BITS > 0) begin : g_idx
      assign in_set = req.address[OFF_W +: SET_W];
    end else begin : g_one_set
      assign in_set = '0;
    end
  endgenerate

  assign accept = req.valid && req.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept)  state_next = ST_LOOKUP;
      ST_LOOKUP: if (advance) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // controls
  always_comb begin
    req.ready = 1'b0;
    advance   = 1'b0;
    case (state)
      ST_IDLE:   req.ready = !clr_busy;
      ST_LOOKUP: advance   = !out_valid || rsp.ready;
      default:   ;
    endcase
    rd_en = req.valid && req.ready;
    wr_en = advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_tag <= in_tag;
      req_set <= in_set;
      req_wr  <= req.req_type;
    end
  end

  salc_store #(
    .NUM_SETS (NUM_SETS),
    .WAYS     (WAYS),
    .TAG_W    (TAG_W),
    .SET_W    (SET_W),
    .RANK_W   (RANK_W)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .rd_en       (rd_en),
    .rd_set      (in_set),
    .wr_en       (wr_en),
    .wr_set      (req_set),
    .wr_tag_row  (wr_tag_row),
    .wr_meta_row (wr_meta_row),
    .rd_tag_row  (rd_tag_row),
    .rd_meta_row (rd_meta_row),
    .clr_busy    (clr_busy)
  );

  salc_policy #(
    .WAYS     (WAYS),
    .TAG_W    (TAG_W),
    .SET_W    (SET_W),
    .RANK_W   (RANK_W),
    .OFF_W    (OFF_W),
    .IDX_BITS (IDX_BITS)
  ) u_policy (
    .tag_row       (rd_tag_row),
    .meta_row      (rd_meta_row),
    .tag           (req_tag),
    .set_idx       (req_set),
    .wr            (req_wr),
    .res           (res),
    .tag_row_next  (wr_tag_row),
    .meta_row_next (wr_meta_row)
  );

  // counters include the access being reported; both wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hit_total  <= '0;
      miss_total <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      if (res.hit) begin
        hit_total <= hit_total + 1'b1;
      end else begin
        miss_total <= miss_total + 1'b1;
      end
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.hit               = out_res.hit;
  assign rsp.way               = out_res.way;
  assign rsp.writeback_valid   = out_res.writeback_valid;
  assign rsp.writeback_address = out_res.writeback_address;
  assign rsp.hit_count         = hit_total;
  assign rsp.miss_count        = miss_total;

  // no access taken while metadata is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !accept)
    else $error("access accepted during clearing pass");

  // row write-back only in the lookup state
  a_wr_in_lookup: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_LOOKUP))
    else $error("store written outside lookup");

  // a finished lookup always leaves a result waiting
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("lookup finished without result");

  // exactly one counter moves per finished lookup
  a_one_count: assert property (@(posedge clk) disable iff (rst)
    advance |=> (hit_total + miss_total) ==
                ($past(hit_total) + $past(miss_total) + 1'b1))
    else $error("hit/miss totals out of step");

  // a hit never evicts
  a_hit_no_wb: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.hit && out_res.writeback_valid))
    else $error("writeback reported on a hit");

endmodule

// ----- tb/sv/salc_lookup_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the cache lookup core: tracks tags, valid/dirty bits and LRU ranks.
// It predicts each result word and compares it with what the core returns.
// Depends on salc_pkg, salc_req_if and salc_rsp_if.
module salc_lookup_checker
  import salc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  salc_req_if         req,
  salc_rsp_if         rsp,
  output int unsigned outstanding,
  output int unsigned fail_count,
  output int unsigned seen_hits,
  output int unsigned seen_misses,
  output int unsigned seen_writebacks
);

  localparam int unsigned NUM_SETS = SALC_NUM_SETS;
  localparam int unsigned WAYS     = SALC_WAYS;
  localparam int unsigned OFF_W    = $clog2(SALC_LINE_BYTES);
  localparam int unsigned SET_W    = $clog2(SALC_NUM_SETS);
  localparam int unsigned TAG_W    = ADDR_W - SET_W - OFF_W;
  localparam int unsigned RANK_W   = $clog2(SALC_WAYS);
  localparam int          NO_WAY   = -1;

  typedef struct packed {
    logic                   hit;
    logic [WAY_FIELD_W-1:0] way;
    logic                   wb_valid;
    logic [ADDR_W-1:0]      wb_address;
    logic [CNT_W-1:0]       hits;
    logic [CNT_W-1:0]       misses;
  } lookup_word_t;

  logic [TAG_W-1:0]  line_tag   [NUM_SETS][WAYS];
  bit                line_valid [NUM_SETS][WAYS];
  bit                line_dirty [NUM_SETS][WAYS];
  logic [RANK_W-1:0] line_rank  [NUM_SETS][WAYS];
  logic [CNT_W-1:0]  hit_total;
  logic [CNT_W-1:0]  miss_total;

  lookup_word_t awaited_words [$];
  lookup_word_t want;

  function automatic void clear_cache_state();
    int s, w;
    for (s = 0; s < NUM_SETS; s++) begin
      for (w = 0; w < WAYS; w++) begin
        line_tag[s][w]   = '0;
        line_valid[s][w] = 1'b0;
        line_dirty[s][w] = 1'b0;
        line_rank[s][w]  = RANK_W'(w);
      end
    end
    hit_total  = '0;
    miss_total = '0;
  endfunction

  // Make way w the most recently used; ranks above its old rank slide down.
  function automatic void promote_way(int s, int w);
    logic [RANK_W-1:0] old_rank;
    int i;
    old_rank = line_rank[s][w];
    for (i = 0; i < WAYS; i++)
      if (line_rank[s][i] > old_rank) line_rank[s][i] = line_rank[s][i] - 1'b1;
    line_rank[s][w] = RANK_W'(WAYS - 1);
  endfunction

  function automatic lookup_word_t predict_lookup(logic [ADDR_W-1:0] addr, logic is_write);
    lookup_word_t w;
    logic [SET_W-1:0] s;
    logic [TAG_W-1:0] t;
    int hit_way, victim, i;
    s = addr[OFF_W +: SET_W];
    t = addr[ADDR_W-1 -: TAG_W];
    w = '0;
    hit_way = NO_WAY;
    // Lowest matching way wins, should two ever match.
    for (i = WAYS - 1; i >= 0; i--)
      if (line_valid[s][i] && line_tag[s][i] == t) hit_way = i;
    if (hit_way != NO_WAY) begin
      hit_total = hit_total + 1'b1;
      seen_hits++;
      w.hit = 1'b1;
      w.way = WAY_FIELD_W'(hit_way);
      if (is_write) line_dirty[s][hit_way] = 1'b1;
      promote_way(s, hit_way);
    end else begin
      miss_total = miss_total + 1'b1;
      seen_misses++;
      victim = 0;
      for (i = 1; i < WAYS; i++)
        if (line_rank[s][i] < line_rank[s][victim]) victim = i;
      if (line_valid[s][victim] && line_dirty[s][victim]) begin
        w.wb_valid   = 1'b1;
        w.wb_address = {line_tag[s][victim], s, {OFF_W{1'b0}}};
        seen_writebacks++;
      end
      line_tag[s][victim]   = t;
      line_valid[s][victim] = 1'b1;
      line_dirty[s][victim] = is_write;
      w.way = WAY_FIELD_W'(victim);
      promote_way(s, victim);
    end
    w.hits   = hit_total;
    w.misses = miss_total;
    return w;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_cache_state();
      awaited_words.delete();
      fail_count      = 0;
      seen_hits       = 0;
      seen_misses     = 0;
      seen_writebacks = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_words.size() == 0) begin
          $display("%0t: result word with nothing expected, actual hit %b way %0d",
                   $time, rsp.hit, rsp.way);
          fail_count++;
        end else begin
          want = awaited_words.pop_front();
          check_field("hit", 32'(want.hit), 32'(rsp.hit));
          check_field("way", 32'(want.way), 32'(rsp.way));
          check_field("writeback_valid", 32'(want.wb_valid), 32'(rsp.writeback_valid));
          check_field("writeback_address", want.wb_address, rsp.writeback_address);
          check_field("hit_count", want.hits, rsp.hit_count);
          check_field("miss_count", want.misses, rsp.miss_count);
        end
      end
      if (req.valid && req.ready)
        awaited_words.push_back(predict_lookup(req.address, req.req_type));
    end
    outstanding <= awaited_words.size();
  end

endmodule

// ----- tb/sv/set_assoc_lru_cache_lookup_core_tb.sv -----
`timescale 1ns / 100ps
// Top of the cache lookup core testbench: clock, reset, access stimulus and verdict.
// Depends on salc_pkg, salc_req_if, salc_rsp_if, salc_lookup_checker and the core.
module set_assoc_lru_cache_lookup_core_tb;
  import salc_pkg::*;

  localparam int unsigned OFF_W  = $clog2(SALC_LINE_BYTES);
  localparam int unsigned SET_W  = $clog2(SALC_NUM_SETS);
  localparam int unsigned TAG_W  = ADDR_W - SET_W - OFF_W;
  localparam int unsigned WORDS_PER_PHASE = 270;
  localparam int unsigned POOL_TAGS = 6;

  // Access kinds on req_type.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  logic clk = 1'b0;
  logic rst;

  // Pacing knobs, percent of cycles: sender idle, receiver stalled.
  int unsigned idle_pct;
  int unsigned stall_pct;

  int unsigned outstanding, fail_count;
  int unsigned seen_hits, seen_misses, seen_writebacks;
  int unsigned words_sent;

  // Small tag pool so that random traffic keeps hitting and evicting.
  logic [TAG_W-1:0] tag_pool [POOL_TAGS];

  salc_req_if req_ch ();
  salc_rsp_if rsp_ch ();

  set_assoc_lru_cache_lookup_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  salc_lookup_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .req             (req_ch),
    .rsp             (rsp_ch),
    .outstanding     (outstanding),
    .fail_count      (fail_count),
    .seen_hits       (seen_hits),
    .seen_misses     (seen_misses),
    .seen_writebacks (seen_writebacks)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: drop ready at random, at the rate the current phase asks for.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hang guard: far beyond the slowest legal run (~1100 words plus the clearing
  // pass after reset).
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] make_addr(logic [TAG_W-1:0] t,
                                                   logic [SET_W-1:0] s,
                                                   logic [OFF_W-1:0] o);
    return {t, s, o};
  endfunction

  // Mostly pool tags over a few hot sets or any set; the rest are raw addresses.
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned r;
    logic [SET_W-1:0] s;
    r = $urandom_range(99);
    if (r >= 85) return $urandom;
    if (r < 45) s = SET_W'($urandom_range(3) * 37);
    else s = SET_W'($urandom);
    return make_addr(tag_pool[$urandom_range(POOL_TAGS - 1)], s, OFF_W'($urandom));
  endfunction

  // Offer one access word; valid stays high straight into the next word when
  // no idle cycle is drawn.
  task automatic send_access(logic [ADDR_W-1:0] addr, logic kind);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.address  <= addr;
    req_ch.req_type <= kind;
    do @(posedge clk); while (!req_ch.ready);
    words_sent++;
  endtask

  // Sender holds off until the checker has every expected word back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int ph, i;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.address  <= '0;
    req_ch.req_type <= REQ_READ;
    idle_pct   = 0;
    stall_pct  <= 0;
    words_sent = 0;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (i = 2; i < POOL_TAGS; i++) tag_pool[i] = TAG_W'($urandom);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no idling.
    // Address extremes: lowest line, top line with all tag bits set.
    send_access(32'h0000_0000, REQ_READ);
    send_access(32'h0000_003F, REQ_READ);             // same line, last byte: hit
    send_access(32'hFFFF_FFFF, REQ_WRITE);            // write miss, dirty fill
    send_access(32'hFFFF_FFC0, REQ_READ);             // hit on it
    // Set 5: fill all four ways dirty, refresh two, then evict in LRU order.
    send_access(make_addr(19'h00011, 7'd5, 6'd0), REQ_WRITE);
    send_access(make_addr(19'h00022, 7'd5, 6'd1), REQ_WRITE);
    send_access(make_addr(19'h00033, 7'd5, 6'd2), REQ_WRITE);
    send_access(make_addr(19'h00044, 7'd5, 6'd3), REQ_WRITE);
    send_access(make_addr(19'h00011, 7'd5, 6'd9), REQ_READ);   // read hit
    send_access(make_addr(19'h00022, 7'd5, 6'd9), REQ_WRITE);  // write hit
    send_access(make_addr(19'h00055, 7'd5, 6'd0), REQ_READ);   // dirty victim
    send_access(make_addr(19'h00066, 7'd5, 6'd0), REQ_READ);
    send_access(make_addr(19'h00077, 7'd5, 6'd0), REQ_READ);
    send_access(make_addr(19'h00033, 7'd5, 6'd0), REQ_READ);
    send_access(make_addr(19'h00088, 7'd5, 6'd0), REQ_READ);   // clean victim
    send_access(make_addr(19'h00066, 7'd5, 6'd0), REQ_WRITE);  // dirtied by hit
    // Set 127: push the all-ones line out for the top writeback address.
    send_access(make_addr(19'h00001, 7'd127, 6'd0), REQ_WRITE);
    send_access(make_addr(19'h00002, 7'd127, 6'd0), REQ_WRITE);
    send_access(make_addr(19'h00003, 7'd127, 6'd0), REQ_READ);
    send_access(make_addr(19'h00004, 7'd127, 6'd63), REQ_READ);
    drain_results();

    // Random part in four pacing phases, draining between them.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 61;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 61;
        end
        default: begin
          idle_pct = 11;
          stall_pct <= 11;
        end
      endcase
      repeat (WORDS_PER_PHASE) send_access(pick_address(), 1'($urandom));
      drain_results();
    end

    // Let any stray result word surface before the verdict.
    repeat (10) @(posedge clk);
    $display("Sent %0d access words across four pacing mixes, no idling to heavy stalls.",
             words_sent);
    $display("Predicted %0d hits, %0d misses and %0d dirty-line writebacks.",
             seen_hits, seen_misses, seen_writebacks);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
